// ----- rtl/sc5_pkg.sv -----
// sc5_pkg: shared types and constants for the socks5 client handshake block
// beat structs for both queue sides, the front-to-back command and the phase enum
// no dependencies
package sc5_pkg;

	// input beat
	typedef struct packed {
		logic       func;
		logic [7:0] rx_byte;
		logic       buffer_end;
	} in_item_t;

	// result beat
	typedef struct packed {
		logic [2:0] event_res;
		logic [7:0] data_byte;
		logic       last_of_buffer;
	} out_item_t;

	// classified command handed from front to back
	typedef struct packed {
		logic       is_start;
		logic [7:0] rx_byte;
		logic       last;
	} cmd_t;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_METHOD = 3'd1,
		PH_AUTH   = 3'd2,
		PH_HEADER = 3'd3,
		PH_DLEN   = 3'd4,
		PH_SKIP   = 3'd5,
		PH_CONN   = 3'd6,
		PH_ERR    = 3'd7
	} phase_t;

	localparam logic [2:0] EV_NONE      = 3'd0;
	localparam logic [2:0] EV_GREET     = 3'd1;
	localparam logic [2:0] EV_AUTH      = 3'd2;
	localparam logic [2:0] EV_CONNECT   = 3'd3;
	localparam logic [2:0] EV_CONNECTED = 3'd4;
	localparam logic [2:0] EV_PAYLOAD   = 3'd5;
	localparam logic [2:0] EV_CHALLENGE = 3'd6;
	localparam logic [2:0] EV_ERROR     = 3'd7;

	localparam logic       FUNC_START = 1'b0;

	localparam logic [7:0] SOCKS_VER     = 8'h05;
	localparam logic [7:0] AUTH_VER      = 8'h01;
	localparam logic [7:0] METHOD_REJECT = 8'hff;
	localparam logic [7:0] ATYP_IPV4     = 8'h01;
	localparam logic [7:0] ATYP_DOMAIN   = 8'h03;
	localparam logic [7:0] ATYP_IPV6     = 8'h04;

	localparam logic [1:0] METHOD_NOAUTH = 2'd0;
	localparam logic [1:0] METHOD_USER   = 2'd2;

	// full reply lengths: header 4 + address + port 2
	localparam logic [8:0] SKIP_IPV4     = 9'd10;
	localparam logic [8:0] SKIP_IPV6     = 9'd22;
	// header 4 + length byte 1 + port 2, name length added on top
	localparam logic [8:0] SKIP_DOM_BASE = 9'd7;
	localparam logic [8:0] HDR_LAST_IDX  = 9'd3;

	// both small queues hold two beats
	localparam logic [1:0] QUEUE_DEPTH = 2'd2;

endpackage

// ----- rtl/sc5_front.sv -----
// sc5_front: input side of the handshake block, accepts and classifies beats
// into a two-entry command queue read by the back end
// depends on sc5_pkg
module sc5_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  sc5_pkg::in_item_t in_item,
	output logic             full,
	output logic             cmd_valid,
	output sc5_pkg::cmd_t    cmd,
	input  logic             cmd_take
);

	sc5_pkg::cmd_t mem_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	logic          do_push;
	logic          do_pop;
	sc5_pkg::cmd_t new_cmd;

	assign full      = (count_q == sc5_pkg::QUEUE_DEPTH);
	assign cmd_valid = (count_q != 2'd0);
	assign do_push   = push && !full;
	assign do_pop    = cmd_take && cmd_valid;

	// classify: start command or received byte
	always_comb begin
		new_cmd.is_start = (in_item.func == sc5_pkg::FUNC_START);
		new_cmd.rx_byte  = in_item.rx_byte;
		new_cmd.last     = in_item.buffer_end;
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign cmd = mem_q[rd_ptr_q];

endmodule

// ----- rtl/sc5_back.sv -----
// sc5_back: handshake sequencer and two-entry result queue
// takes classified commands from sc5_front, one per cycle while the result queue is not full
// depends on sc5_pkg
module sc5_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              use_credentials,
	input  logic              cmd_valid,
	input  sc5_pkg::cmd_t     cmd,
	output logic              cmd_take,
	input  logic              pop,
	output logic              empty,
	output sc5_pkg::out_item_t out_item
);

	sc5_pkg::phase_t phase_q, phase_d;
	logic [8:0]      byte_count_q, byte_count_d;
	logic [7:0]      version_q, version_d;
	logic [7:0]      status_q, status_d;
	logic [8:0]      skip_total_q, skip_total_d;
	logic [1:0]      offered_q, offered_d;

	logic [2:0]      ev;
	logic [7:0]      data;
	logic [8:0]      bc_inc;
	logic [7:0]      b;
	logic            method_ok;
	logic            method_rej;
	logic            auth_ok;
	logic            hdr_ok;

	sc5_pkg::out_item_t oq_q [2];
	logic               owr_q;
	logic               ord_q;
	logic [1:0]         ocount_q;
	logic               opop;
	sc5_pkg::out_item_t res;

	assign cmd_take = cmd_valid && (ocount_q != sc5_pkg::QUEUE_DEPTH);
	assign b        = cmd.rx_byte;
	assign bc_inc   = byte_count_q + 9'd1;

	assign method_ok  = (version_q == sc5_pkg::SOCKS_VER) && (b == {6'd0, offered_q});
	assign method_rej = (offered_q == sc5_pkg::METHOD_NOAUTH) && (b == sc5_pkg::METHOD_REJECT);
	assign auth_ok    = (version_q == sc5_pkg::AUTH_VER) && (b == 8'h00);
	assign hdr_ok     = (version_q == sc5_pkg::SOCKS_VER) && (status_q == 8'h00);

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (cmd.is_start) begin
			phase_d = sc5_pkg::PH_METHOD;
		end else begin
			unique case (phase_q)
				sc5_pkg::PH_METHOD: begin
					if (byte_count_q != 9'd0) begin
						if (method_ok) begin
							phase_d = (offered_q == sc5_pkg::METHOD_NOAUTH) ?
								sc5_pkg::PH_HEADER : sc5_pkg::PH_AUTH;
						end else if (method_rej) begin
							phase_d = sc5_pkg::PH_IDLE;
						end else begin
							phase_d = sc5_pkg::PH_ERR;
						end
					end
				end
				sc5_pkg::PH_AUTH: begin
					if (byte_count_q != 9'd0) begin
						phase_d = auth_ok ? sc5_pkg::PH_HEADER : sc5_pkg::PH_ERR;
					end
				end
				sc5_pkg::PH_HEADER: begin
					if (byte_count_q >= sc5_pkg::HDR_LAST_IDX) begin
						if (!hdr_ok) begin
							phase_d = sc5_pkg::PH_ERR;
						end else if (b == sc5_pkg::ATYP_IPV4 || b == sc5_pkg::ATYP_IPV6) begin
							phase_d = sc5_pkg::PH_SKIP;
						end else if (b == sc5_pkg::ATYP_DOMAIN) begin
							phase_d = sc5_pkg::PH_DLEN;
						end else begin
							phase_d = sc5_pkg::PH_ERR;
						end
					end
				end
				sc5_pkg::PH_DLEN: phase_d = sc5_pkg::PH_SKIP;
				sc5_pkg::PH_SKIP: begin
					if (bc_inc >= skip_total_q) begin
						phase_d = sc5_pkg::PH_CONN;
					end
				end
				default: phase_d = phase_q;
			endcase
		end
	end

	// event, data and datapath registers
	always_comb begin
		ev           = sc5_pkg::EV_NONE;
		data         = 8'd0;
		byte_count_d = byte_count_q;
		version_d    = version_q;
		status_d     = status_q;
		skip_total_d = skip_total_q;
		offered_d    = offered_q;
		if (cmd.is_start) begin
			offered_d    = use_credentials ? sc5_pkg::METHOD_USER : sc5_pkg::METHOD_NOAUTH;
			byte_count_d = 9'd0;
			version_d    = 8'd0;
			status_d     = 8'd0;
			skip_total_d = 9'd0;
			ev           = sc5_pkg::EV_GREET;
			data         = {6'd0, offered_d};
		end else begin
			unique case (phase_q)
				sc5_pkg::PH_METHOD: begin
					if (byte_count_q == 9'd0) begin
						version_d    = b;
						byte_count_d = 9'd1;
					end else begin
						byte_count_d = 9'd0;
						if (method_ok) begin
							ev = (offered_q == sc5_pkg::METHOD_NOAUTH) ?
								sc5_pkg::EV_CONNECT : sc5_pkg::EV_AUTH;
						end else if (method_rej) begin
							ev = sc5_pkg::EV_CHALLENGE;
						end else begin
							ev = sc5_pkg::EV_ERROR;
						end
					end
				end
				sc5_pkg::PH_AUTH: begin
					if (byte_count_q == 9'd0) begin
						version_d    = b;
						byte_count_d = 9'd1;
					end else begin
						byte_count_d = 9'd0;
						ev = auth_ok ? sc5_pkg::EV_CONNECT : sc5_pkg::EV_ERROR;
					end
				end
				sc5_pkg::PH_HEADER: begin
					byte_count_d = bc_inc;
					if (byte_count_q == 9'd0) begin
						version_d = b;
					end else if (byte_count_q == 9'd1) begin
						status_d = b;
					end else if (byte_count_q >= sc5_pkg::HDR_LAST_IDX) begin
						if (!hdr_ok) begin
							ev = sc5_pkg::EV_ERROR;
						end else if (b == sc5_pkg::ATYP_IPV4) begin
							skip_total_d = sc5_pkg::SKIP_IPV4;
						end else if (b == sc5_pkg::ATYP_IPV6) begin
							skip_total_d = sc5_pkg::SKIP_IPV6;
						end else if (b != sc5_pkg::ATYP_DOMAIN) begin
							ev = sc5_pkg::EV_ERROR;
						end
					end
				end
				sc5_pkg::PH_DLEN: begin
					skip_total_d = {1'b0, b} + sc5_pkg::SKIP_DOM_BASE;
					byte_count_d = bc_inc;
				end
				sc5_pkg::PH_SKIP: begin
					byte_count_d = bc_inc;
					if (bc_inc >= skip_total_q) begin
						ev           = sc5_pkg::EV_CONNECTED;
						byte_count_d = 9'd0;
					end
				end
				sc5_pkg::PH_CONN: begin
					ev   = sc5_pkg::EV_PAYLOAD;
					data = b;
				end
				default: ev = sc5_pkg::EV_NONE;
			endcase
		end
	end

	always_comb begin
		res.event_res      = ev;
		res.data_byte      = data;
		res.last_of_buffer = cmd.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= sc5_pkg::PH_IDLE;
			byte_count_q <= 9'd0;
			version_q    <= 8'd0;
			status_q     <= 8'd0;
			skip_total_q <= 9'd0;
			offered_q    <= 2'd0;
		end else if (cmd_take) begin
			phase_q      <= phase_d;
			byte_count_q <= byte_count_d;
			version_q    <= version_d;
			status_q     <= status_d;
			skip_total_q <= skip_total_d;
			offered_q    <= offered_d;
		end
	end

	// result queue
	assign empty    = (ocount_q == 2'd0);
	assign opop     = pop && !empty;
	assign out_item = oq_q[ord_q];

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			oq_q[owr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q    <= 1'b0;
			ord_q    <= 1'b0;
			ocount_q <= 2'd0;
		end else begin
			if (cmd_take) begin
				owr_q <= !owr_q;
			end
			if (opop) begin
				ord_q <= !ord_q;
			end
			case ({cmd_take, opop})
				2'b10:   ocount_q <= ocount_q + 2'd1;
				2'b01:   ocount_q <= ocount_q - 2'd1;
				default: ocount_q <= ocount_q;
			endcase
		end
	end

endmodule

// ----- rtl/socks5_client_handshake.sv -----
// socks5_client_handshake: top level of the socks5 client handshake sequencer
// holds the use_credentials register and joins sc5_front and sc5_back
// depends on sc5_pkg, sc5_front, sc5_back
//
// the block takes one beat per cycle while full is low and gives exactly one result beat
// per input beat; a pushed beat is registered in the command queue, passes through the
// sequencer into the result queue, where it is registered and can be popped, and with
// pop held high the throughput is one beat per clock; the only loop is the phase/counter
// update in the sequencer; both queues hold two beats, so full rises only after the result
// side has stalled; use_credentials is written through the cfg channel, which is always
// ready, and is sampled when a start beat is processed
module socks5_client_handshake (
	input  logic               clk,
	input  logic               arst_n,
	// input queue side
	input  logic               push,
	output logic               full,
	input  sc5_pkg::in_item_t  in_item,
	// result queue side
	output logic               empty,
	input  logic               pop,
	output sc5_pkg::out_item_t out_item,
	// configuration write channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_data
);

	logic          use_credentials_q;
	logic          cmd_valid;
	logic          cmd_take;
	sc5_pkg::cmd_t cmd;

	// register can always take a write
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_credentials_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			use_credentials_q <= cfg_data;
		end
	end

	// front: accept and classify beats
	sc5_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.in_item   (in_item),
		.full      (full),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take)
	);

	// back: sequencer plus result queue
	sc5_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.use_credentials (use_credentials_q),
		.cmd_valid       (cmd_valid),
		.cmd             (cmd),
		.cmd_take        (cmd_take),
		.pop             (pop),
		.empty           (empty),
		.out_item        (out_item)
	);

endmodule

// ----- rtl/sc5_checker.sv -----
// sc5_checker: port-level assertions for socks5_client_handshake
// attached by the bind statement at the end of this file
// depends on sc5_pkg
module sc5_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               full,
	input logic               empty,
	input logic               pop,
	input sc5_pkg::out_item_t out_item
);

	// input side only backs up behind a stalled result side
	a_full_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !empty)
		else $error("full while no result waits");

	// data byte is zero except for greeting and payload beats
	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_item.event_res != sc5_pkg::EV_GREET
			&& out_item.event_res != sc5_pkg::EV_PAYLOAD) |-> out_item.data_byte == 8'd0)
		else $error("nonzero data byte on control event");

	// greeting offers only method 0 or 2
	a_greet_method: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_item.event_res == sc5_pkg::EV_GREET) |->
			(out_item.data_byte == 8'h00 || out_item.data_byte == 8'h02))
		else $error("greeting offers unknown method");

	// waiting result holds until popped
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_item)))
		else $error("waiting result changed");

endmodule

bind socks5_client_handshake sc5_checker u_sc5_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.full     (full),
	.empty    (empty),
	.pop      (pop),
	.out_item (out_item)
);

// ----- tb/socks5_client_handshake_test.sv -----
// socks5_client_handshake_test: self-checking bench for the socks5 client handshake block
// a scoreboard class predicts one result beat per input beat; plain tasks drive the input side,
// an initial block pops the result side; depends on sc5_pkg and socks5_client_handshake
module socks5_client_handshake_test;
	import sc5_pkg::*;

	// watchdog budget, far above the slowest legal run of this stimulus
	localparam int unsigned CYCLE_LIMIT = 500000;
	// input beats to accept before the run winds down
	localparam int unsigned BEAT_TARGET = 760;
	// random beats per configuration phase
	localparam int unsigned PHASE_BEATS = 100;
	// cycles to let pass after the last result
	localparam int unsigned SETTLE_CYCLES = 4;
	// cap on printed mismatch lines
	localparam int unsigned REPORT_CAP = 40;
	localparam logic FUNC_BYTE = ~FUNC_START;

	// tracks the handshake phase and holds the result beats still owed by the block
	class handshake_scoreboard;
		logic       cred;
		phase_t     phase;
		logic [8:0] reply_idx;
		logic [7:0] ver_seen;
		logic [7:0] status_seen;
		logic [8:0] reply_len;
		logic [1:0] method;
		out_item_t  owed_q[$];
		int unsigned errors;

		function new();
			cred = 1'b0;
			phase = PH_IDLE;
			reply_idx = '0;
			ver_seen = '0;
			status_seen = '0;
			reply_len = '0;
			method = METHOD_NOAUTH;
			errors = 0;
		endfunction

		// one accepted input beat: advance the phase and queue the result it causes
		function void note_input(in_item_t it);
			out_item_t  want;
			logic [7:0] b;
			b = it.rx_byte;
			want.event_res = EV_NONE;
			want.data_byte = 8'h00;
			want.last_of_buffer = it.buffer_end;
			if (it.func == FUNC_START) begin
				// a start restarts the handshake from any phase
				method = cred ? METHOD_USER : METHOD_NOAUTH;
				reply_idx = '0;
				ver_seen = '0;
				status_seen = '0;
				reply_len = '0;
				phase = PH_METHOD;
				want.event_res = EV_GREET;
				want.data_byte = {6'b0, method};
			end else begin
				case (phase)
					PH_METHOD: begin
						if (reply_idx == 9'd0) begin
							ver_seen = b;
							reply_idx = 9'd1;
						end else begin
							reply_idx = '0;
							if (ver_seen == SOCKS_VER && b == {6'b0, method}) begin
								if (method == METHOD_NOAUTH) begin
									want.event_res = EV_CONNECT;
									phase = PH_HEADER;
								end else begin
									want.event_res = EV_AUTH;
									phase = PH_AUTH;
								end
							end else if (method == METHOD_NOAUTH && b == METHOD_REJECT) begin
								// proxy wants credentials, software restarts
								want.event_res = EV_CHALLENGE;
								phase = PH_IDLE;
							end else begin
								want.event_res = EV_ERROR;
								phase = PH_ERR;
							end
						end
					end
					PH_AUTH: begin
						if (reply_idx == 9'd0) begin
							ver_seen = b;
							reply_idx = 9'd1;
						end else begin
							reply_idx = '0;
							if (ver_seen == AUTH_VER && b == 8'h00) begin
								want.event_res = EV_CONNECT;
								phase = PH_HEADER;
							end else begin
								want.event_res = EV_ERROR;
								phase = PH_ERR;
							end
						end
					end
					PH_HEADER: begin
						if (reply_idx == 9'd0) begin
							ver_seen = b;
						end else if (reply_idx == 9'd1) begin
							status_seen = b;
						end else if (reply_idx >= HDR_LAST_IDX) begin
							// verdict on the address type byte
							if (ver_seen != SOCKS_VER || status_seen != 8'h00) begin
								want.event_res = EV_ERROR;
								phase = PH_ERR;
							end else if (b == ATYP_IPV4) begin
								reply_len = SKIP_IPV4;
								phase = PH_SKIP;
							end else if (b == ATYP_IPV6) begin
								reply_len = SKIP_IPV6;
								phase = PH_SKIP;
							end else if (b == ATYP_DOMAIN) begin
								phase = PH_DLEN;
							end else begin
								want.event_res = EV_ERROR;
								phase = PH_ERR;
							end
						end
						reply_idx = reply_idx + 9'd1;
					end
					PH_DLEN: begin
						reply_len = {1'b0, b} + SKIP_DOM_BASE;
						reply_idx = reply_idx + 9'd1;
						phase = PH_SKIP;
					end
					PH_SKIP: begin
						reply_idx = reply_idx + 9'd1;
						if (reply_idx >= reply_len) begin
							want.event_res = EV_CONNECTED;
							phase = PH_CONN;
							reply_idx = '0;
						end
					end
					PH_CONN: begin
						want.event_res = EV_PAYLOAD;
						want.data_byte = b;
					end
					default: begin
						// idle and error ignore bytes
					end
				endcase
			end
			owed_q.insert(owed_q.size(), want);
		endfunction

		function void report(string what, int unsigned want, int unsigned got);
			errors++;
			if (errors <= REPORT_CAP)
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
		endfunction

		// one accepted result beat against the oldest owed one
		function void check_result(out_item_t got);
			out_item_t want;
			if (owed_q.size() == 0) begin
				errors++;
				if (errors <= REPORT_CAP)
					$display("%0t: unexpected result, expected none, actual event %0d data %0h",
						$time, got.event_res, got.data_byte);
				return;
			end
			want = owed_q.pop_front();
			if (got.event_res !== want.event_res)
				report("event_res", want.event_res, got.event_res);
			if (got.data_byte !== want.data_byte)
				report("data_byte", want.data_byte, got.data_byte);
			if (got.last_of_buffer !== want.last_of_buffer)
				report("last_of_buffer", want.last_of_buffer, got.last_of_buffer);
		endfunction
	endclass

	logic      clk;
	logic      arst_n = 1'b0;
	logic      push = 1'b0;
	logic      full;
	in_item_t  in_item = '0;
	logic      empty;
	logic      pop = 1'b0;
	out_item_t out_item;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	logic      cfg_data = 1'b0;

	handshake_scoreboard sb = new();
	in_item_t    stim_q[$];
	int unsigned beats_sent = 0;
	int unsigned cycle_count = 0;
	// no sender gaps while set, gives back-to-back stretches
	bit          quiet = 0;

	socks5_client_handshake u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.in_item   (in_item),
		.empty     (empty),
		.pop       (pop),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic in_item_t mk_beat(logic f, logic [7:0] b);
		in_item_t it;
		it.func = f;
		it.rx_byte = b;
		it.buffer_end = 1'($urandom_range(0, 1));
		return it;
	endfunction

	function automatic void add_start();
		stim_q.insert(stim_q.size(), mk_beat(FUNC_START, 8'($urandom_range(0, 255))));
	endfunction

	function automatic void add_rx(logic [7:0] b);
		stim_q.insert(stim_q.size(), mk_beat(FUNC_BYTE, b));
	endfunction

	function automatic logic [7:0] rnd_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	// hold push until the beat is taken, then maybe leave a gap
	task automatic send_beat(input in_item_t it);
		int unsigned gap;
		push <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (full);
		sb.note_input(it);
		beats_sent++;
		gap = quiet ? 0 : pick_gap();
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic run_queue();
		while (stim_q.size() != 0)
			send_beat(stim_q.pop_front());
	endtask

	// sender stops until every owed result has come, then waits out SETTLE_CYCLES
	task automatic settle();
		push <= 1'b0;
		while (sb.owed_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register write only with the block drained
	task automatic write_cred(input logic v);
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.cred = v;
	endtask

	// one handshake with random content, now and then corrupted or cut short
	task automatic build_session(input logic cred);
		int unsigned r;
		int unsigned n;
		logic [7:0]  atyp;
		// stray bytes ahead of the start land in whatever phase is left over
		if ($urandom_range(0, 99) < 6)
			repeat ($urandom_range(1, 3)) add_rx(rnd_byte());
		add_start();
		// method reply
		r = $urandom_range(0, 99);
		add_rx(r < 6 ? rnd_byte() : SOCKS_VER);
		if (r >= 6 && r < 12)
			add_rx(rnd_byte());
		else if (r >= 12 && r < 24)
			add_rx(METHOD_REJECT);
		else
			add_rx({6'b0, cred ? METHOD_USER : METHOD_NOAUTH});
		// auth reply only when credentials were offered
		if (cred) begin
			r = $urandom_range(0, 99);
			add_rx(r < 6 ? rnd_byte() : AUTH_VER);
			add_rx((r >= 6 && r < 12) ? rnd_byte() : 8'h00);
		end
		// connect reply header: version, status, reserved, address type
		r = $urandom_range(0, 99);
		add_rx(r < 5 ? rnd_byte() : SOCKS_VER);
		add_rx((r >= 5 && r < 10) ? rnd_byte() : 8'h00);
		add_rx(rnd_byte());
		if (r >= 10 && r < 16) begin
			atyp = rnd_byte();
		end else begin
			case ($urandom_range(0, 2))
				0: atyp = ATYP_IPV4;
				1: atyp = ATYP_IPV6;
				default: atyp = ATYP_DOMAIN;
			endcase
		end
		add_rx(atyp);
		// bound address
		n = 0;
		if (atyp == ATYP_IPV4) begin
			n = 4;
		end else if (atyp == ATYP_IPV6) begin
			n = 16;
		end else if (atyp == ATYP_DOMAIN) begin
			// mostly short names, a few near the longest
			n = ($urandom_range(0, 99) < 5) ? $urandom_range(200, 255) : $urandom_range(0, 20);
			add_rx(8'(n));
		end
		repeat (n) add_rx(rnd_byte());
		// port, then some payload
		repeat (2) add_rx(rnd_byte());
		repeat ($urandom_range(0, 12)) add_rx(rnd_byte());
		// cut short, the next start restarts mid-handshake
		if ($urandom_range(0, 99) < 10)
			repeat ($urandom_range(1, stim_q.size() - 1)) void'(stim_q.pop_back());
	endtask

	// result side: random stalls with calm stretches in between
	initial begin
		int unsigned stall;
		int unsigned calm;
		stall = 0;
		calm = 0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (stall != 0) begin
				pop <= 1'b0;
				stall--;
			end else begin
				pop <= 1'b1;
				if (calm != 0) begin
					calm--;
				end else if ($urandom_range(0, 99) < 3) begin
					calm = $urandom_range(30, 80);
				end else begin
					stall = pick_gap();
				end
			end
			@(posedge clk);
			if (pop && !empty)
				sb.check_result(out_item);
		end
	end

	// watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("socks5_client_handshake regression: fail");
		$finish;
	end

	initial begin
		int unsigned phase_idx;
		int unsigned target;
		logic        cred;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, no-auth offered after reset
		add_rx(8'hff);                     // byte while idle
		add_start();
		add_rx(SOCKS_VER);
		add_rx(METHOD_REJECT);             // no-auth refused, challenge
		add_rx(8'h00);                     // idle again
		add_start();
		add_rx(8'h04);
		add_rx(8'h00);                     // bad version, error
		add_rx(8'h55);                     // ignored in error
		run_queue();

		// directed, credentials, domain of length zero, payload extremes
		write_cred(1'b1);
		add_start();
		add_rx(SOCKS_VER);
		add_rx({6'b0, METHOD_USER});
		add_rx(AUTH_VER);
		add_rx(8'h00);
		add_rx(SOCKS_VER);
		add_rx(8'h00);
		add_rx(8'h00);
		add_rx(ATYP_DOMAIN);
		add_rx(8'h00);
		add_rx(8'haa);
		add_rx(8'hbb);                     // second port byte, connected
		add_rx(8'hff);
		add_rx(8'h00);
		run_queue();

		// random phases, each with its own register setting
		phase_idx = 0;
		while (beats_sent < BEAT_TARGET) begin
			case (phase_idx % 4)
				0: cred = 1'b0;
				1: cred = 1'b1;
				default: cred = 1'($urandom_range(0, 1));
			endcase
			write_cred(cred);
			target = beats_sent + PHASE_BEATS;
			while (beats_sent < target) begin
				quiet = ($urandom_range(0, 3) == 0);
				build_session(cred);
				run_queue();
			end
			phase_idx++;
		end
		quiet = 0;

		// wait out every owed result, stray late results still get caught
		settle();
		if (sb.errors == 0 && sb.owed_q.size() == 0) begin
			$display("socks5_client_handshake regression: pass");
		end else begin
			$display("socks5_client_handshake regression: fail");
		end
		$finish;
	end
endmodule

// ----- filelist.f -----
rtl/sc5_pkg.sv
rtl/sc5_front.sv
rtl/sc5_back.sv
rtl/socks5_client_handshake.sv
rtl/sc5_checker.sv
tb/socks5_client_handshake_test.sv
